### design/mpa_pkg.sv
// Shared types and constants for the max pooling with argmax unit.
// No dependencies; imported by max_pool_with_argmax_unit.
package mpa_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_WIDTH  = 3'd0,
    REG_POOL_HEIGHT = 3'd1,
    REG_IN_WIDTH    = 3'd2,
    REG_IN_HEIGHT   = 3'd3,
    REG_CHANNELS    = 3'd4
  } cfg_index_t;

  // Widths of the register fields inside cfg_data
  localparam int POOL_FIELD_W = 4;
  localparam int DIM_FIELD_W  = 6;
  localparam int CHAN_FIELD_W = 4;

  // Fixed result field widths
  localparam int POS_W      = 5;
  localparam int CHAN_OUT_W = 3;

  // Input opcode and result kind
  localparam logic OP_FORWARD  = 1'b0;
  localparam logic OP_BACKWARD = 1'b1;
  localparam logic KIND_MAX    = 1'b0;
  localparam logic KIND_GRAD   = 1'b1;

  // Register value of zero reads as one; above the limit saturates.
  function automatic int clamp_cfg(int v, int hi);
    int r;
    if (v == 0) r = 1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

### design/max_pool_with_argmax_unit.sv
// Max pooling with argmax over a streamed feature map, plus gradient routing.
// Channel              Handshake                 Payload
// s_ (input items)     s_tvalid / s_tready       s_tuser opcode, s_tdata sample
// m_ (result items)    m_tvalid / m_tready       m_tuser kind, m_tlast frame_end, m_tdata
// cfg (register write) cfg_valid / cfg_ready     cfg_index, cfg_data
// One item per cycle sustained while results are taken. Stage 1 (accept edge) reads the
// running-max and argmax memories; stage 2 compares and writes back, with a one-entry
// bypass for an entry written at the edge it was read; results load the output register.
// Reset clears counters and pipeline valids and sets config defaults; memories stay as is.
// A full, unread output register stalls stage 2; input items still enter while
// stage 2 holds an item that gives no result or can move into a freed output register.
// Depends on mpa_pkg.
module max_pool_with_argmax_unit #(
  parameter int MAX_DIM      = 32,
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_POOL     = 8,
  parameter int VALUE_WIDTH  = 16
) (
  input  logic clk,
  input  logic rst,
  // input items
  input  logic s_tvalid,
  output logic s_tready,
  input  logic s_tuser,   // [0] opcode
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,   // sample
  // result items
  output logic m_tvalid,
  input  logic m_tready,
  output logic m_tuser,   // [0] kind
  output logic m_tlast,   // frame_end
  // result_value, pos_x, pos_y, channel_index (low bit first)
  output logic [((VALUE_WIDTH+2*mpa_pkg::POS_W+mpa_pkg::CHAN_OUT_W+7)/8)*8-1:0] m_tdata,
  // configuration writes
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mpa_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int POOL_W = $clog2(MAX_POOL + 1);
  localparam int SUM_W  = ((DIM_W > POOL_W) ? DIM_W : POOL_W) + 2;
  localparam int RES_W  = VALUE_WIDTH + 2 * POS_W + CHAN_OUT_W;
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
  localparam int RM_AW  = DIM_W + CH_W;
  localparam int BP_AW  = 2 * DIM_W + CH_W;
  localparam int POSS_W = 2 * DIM_W;

  localparam int PW_RST = clamp_cfg(2, MAX_POOL);
  localparam int PH_RST = clamp_cfg(2, MAX_POOL);
  localparam int W_RST  = clamp_cfg(32, MAX_DIM);
  localparam int H_RST  = clamp_cfg(32, MAX_DIM);
  localparam int C_RST  = clamp_cfg(8, MAX_CHANNELS);

  function automatic logic [POS_W-1:0] dim_to_pos(logic [DIM_W-1:0] v);
    logic [DIM_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, v};
    return t[POS_W-1:0];
  endfunction

  function automatic logic [CHAN_OUT_W-1:0] ch_to_out(logic [CH_W-1:0] v);
    logic [CH_W+CHAN_OUT_W-1:0] t;
    t = {{CHAN_OUT_W{1'b0}}, v};
    return t[CHAN_OUT_W-1:0];
  endfunction

  // ---------------- configuration (stored already clamped) ----------------
  logic [POOL_W-1:0] pw, ph;
  logic [DIM_W:0]    w, h;
  logic [CH_W:0]     c;
  logic              cfg_hit;
  logic              cfg_known;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index_t'(cfg_index))
      REG_POOL_WIDTH, REG_POOL_HEIGHT, REG_IN_WIDTH, REG_IN_HEIGHT,
      REG_CHANNELS: cfg_known = 1'b1;
      default:      cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw <= POOL_W'(PW_RST);
      ph <= POOL_W'(PH_RST);
      w  <= (DIM_W+1)'(W_RST);
      h  <= (DIM_W+1)'(H_RST);
      c  <= (CH_W+1)'(C_RST);
    end else if (cfg_hit) begin
      unique case (cfg_index_t'(cfg_index))
        REG_POOL_WIDTH:
          pw <= POOL_W'(clamp_cfg(int'(cfg_data[POOL_FIELD_W-1:0]), MAX_POOL));
        REG_POOL_HEIGHT:
          ph <= POOL_W'(clamp_cfg(int'(cfg_data[POOL_FIELD_W-1:0]), MAX_POOL));
        REG_IN_WIDTH:
          w <= (DIM_W+1)'(clamp_cfg(int'(cfg_data[DIM_FIELD_W-1:0]), MAX_DIM));
        REG_IN_HEIGHT:
          h <= (DIM_W+1)'(clamp_cfg(int'(cfg_data[DIM_FIELD_W-1:0]), MAX_DIM));
        REG_CHANNELS:
          c <= (CH_W+1)'(clamp_cfg(int'(cfg_data[CHAN_FIELD_W-1:0]), MAX_CHANNELS));
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: stream position counters ----------------
  logic              accept, opcode;
  logic [VALUE_WIDTH-1:0] sample;

  // forward position: input x, y, channel, window offsets and pooled coords
  logic [DIM_W-1:0]  fx, fy, fpx, fpy;
  logic [POOL_W-1:0] fxm, fym;
  logic [CH_W-1:0]   fch;
  // backward position: pooled col/row, channel, and the input base of the window
  logic [DIM_W-1:0]  bcol, brow, bxb, byb;
  logic [CH_W-1:0]   bch;

  logic f_ch_wrap, f_y_wrap, f_x_wrap, f_ym_wrap, f_xm_wrap;
  logic b_ch_wrap, b_row_last, b_col_last;
  logic f_first, f_last, f_frame_end, b_frame_end;
  logic [SUM_W-1:0] bx_sum, by_sum;

  assign opcode = s_tuser;
  assign sample = s_tdata[VALUE_WIDTH-1:0];
  assign accept = s_tvalid && s_tready;

  assign f_ch_wrap = ({1'b0, fch} + 1'b1) == c;
  assign f_y_wrap  = ({1'b0, fy} + 1'b1) == h;
  assign f_x_wrap  = ({1'b0, fx} + 1'b1) == w;
  assign f_ym_wrap = (fym + 1'b1) == ph;
  assign f_xm_wrap = (fxm + 1'b1) == pw;

  assign f_first     = (fxm == '0) && (fym == '0);
  assign f_last      = (f_xm_wrap || f_x_wrap) && (f_ym_wrap || f_y_wrap);
  assign f_frame_end = f_x_wrap && f_y_wrap && f_ch_wrap;

  // last pooled column/row when the next window would start past the map edge
  assign bx_sum     = SUM_W'(bxb) + SUM_W'(pw);
  assign by_sum     = SUM_W'(byb) + SUM_W'(ph);
  assign b_ch_wrap  = ({1'b0, bch} + 1'b1) == c;
  assign b_row_last = by_sum >= SUM_W'(h);
  assign b_col_last = bx_sum >= SUM_W'(w);
  assign b_frame_end = b_col_last && b_row_last && b_ch_wrap;

  always_ff @(posedge clk) begin
    if (rst || (cfg_hit && cfg_known)) begin
      fx <= '0; fy <= '0; fpx <= '0; fpy <= '0; fxm <= '0; fym <= '0; fch <= '0;
      bcol <= '0; brow <= '0; bxb <= '0; byb <= '0; bch <= '0;
    end else if (accept) begin
      if (opcode == OP_FORWARD) begin
        if (!f_ch_wrap) begin
          fch <= fch + 1'b1;
        end else begin
          fch <= '0;
          if (!f_y_wrap) begin
            fy <= fy + 1'b1;
            if (f_ym_wrap) begin
              fym <= '0;
              fpy <= fpy + 1'b1;
            end else begin
              fym <= fym + 1'b1;
            end
          end else begin
            fy  <= '0;
            fym <= '0;
            fpy <= '0;
            if (!f_x_wrap) begin
              fx <= fx + 1'b1;
              if (f_xm_wrap) begin
                fxm <= '0;
                fpx <= fpx + 1'b1;
              end else begin
                fxm <= fxm + 1'b1;
              end
            end else begin
              fx  <= '0;
              fxm <= '0;
              fpx <= '0;
            end
          end
        end
      end else begin
        if (!b_ch_wrap) begin
          bch <= bch + 1'b1;
        end else begin
          bch <= '0;
          if (!b_row_last) begin
            brow <= brow + 1'b1;
            byb  <= by_sum[DIM_W-1:0];
          end else begin
            brow <= '0;
            byb  <= '0;
            if (!b_col_last) begin
              bcol <= bcol + 1'b1;
              bxb  <= bx_sum[DIM_W-1:0];
            end else begin
              bcol <= '0;
              bxb  <= '0;
            end
          end
        end
      end
    end
  end

  // ---------------- memories ----------------
  logic [VALUE_WIDTH-1:0] rm_mem [2**RM_AW];
  logic [POSS_W-1:0]      bp_mem [2**BP_AW];
  logic [RM_AW-1:0]       rm_raddr;
  logic [BP_AW-1:0]       bp_raddr;
  logic [VALUE_WIDTH-1:0] rm_rdata;
  logic [POSS_W-1:0]      bp_rdata;

  assign rm_raddr = {fpy, fch};
  assign bp_raddr = (opcode == OP_FORWARD) ? {fpx, fpy, fch} : {bcol, brow, bch};

  // ---------------- stage 2 registers ----------------
  logic                   s2_valid, s2_op, s2_first, s2_last, s2_fend;
  logic signed [VALUE_WIDTH-1:0] s2_val;
  logic [DIM_W-1:0]       s2_px, s2_py;
  logic [CH_W-1:0]        s2_ch;
  logic [RM_AW-1:0]       s2_rm_addr;
  logic [BP_AW-1:0]       s2_bp_addr;
  logic [POSS_W-1:0]      s2_pos;
  logic                   rm_byp, bp_byp;
  logic [VALUE_WIDTH-1:0] rm_byp_data;
  logic [POSS_W-1:0]      bp_byp_data;

  logic signed [VALUE_WIDTH-1:0] cur_max, new_max;
  logic [POSS_W-1:0]      arg_pos;
  logic                   upd, has_res, out_free, s2_adv, rm_we;

  assign cur_max  = rm_byp ? rm_byp_data : rm_rdata;
  assign arg_pos  = bp_byp ? bp_byp_data : bp_rdata;
  assign upd      = s2_first || (s2_val > cur_max);
  assign new_max  = upd ? s2_val : cur_max;
  assign has_res  = (s2_op == OP_BACKWARD) || s2_last;
  assign out_free = !m_tvalid || m_tready;
  assign s2_adv   = s2_valid && (!has_res || out_free);
  assign s_tready = !s2_valid || s2_adv;
  assign rm_we    = s2_adv && (s2_op == OP_FORWARD) && upd;

  always_ff @(posedge clk) begin
    if (accept) begin
      rm_rdata <= rm_mem[rm_raddr];
      bp_rdata <= bp_mem[bp_raddr];
    end
    if (rm_we) begin
      rm_mem[s2_rm_addr] <= s2_val;
      bp_mem[s2_bp_addr] <= s2_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  // payload and bypass captured with the read; an entry written at the read edge
  // is taken from the bypass, since the memory returns the old contents
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_op       <= opcode;
      s2_val      <= sample;
      s2_first    <= f_first;
      s2_last     <= f_last;
      s2_fend     <= (opcode == OP_FORWARD) ? f_frame_end : b_frame_end;
      s2_px       <= fpx;
      s2_py       <= fpy;
      s2_ch       <= (opcode == OP_FORWARD) ? fch : bch;
      s2_rm_addr  <= rm_raddr;
      s2_bp_addr  <= bp_raddr;
      s2_pos      <= {fx, fy};
      rm_byp      <= rm_we && (s2_rm_addr == rm_raddr);
      bp_byp      <= rm_we && (s2_bp_addr == bp_raddr);
      rm_byp_data <= s2_val;
      bp_byp_data <= s2_pos;
    end
  end

  // ---------------- output register ----------------
  logic [VALUE_WIDTH-1:0] o_val;
  logic [POS_W-1:0]       o_px, o_py;
  logic [CHAN_OUT_W-1:0]  o_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_adv && has_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && has_res) begin
      m_tlast <= s2_fend;
      o_ch    <= ch_to_out(s2_ch);
      if (s2_op == OP_FORWARD) begin
        m_tuser <= KIND_MAX;
        o_val   <= new_max;
        o_px    <= dim_to_pos(s2_px);
        o_py    <= dim_to_pos(s2_py);
      end else begin
        m_tuser <= KIND_GRAD;
        o_val   <= s2_val;
        o_px    <= dim_to_pos(arg_pos[POSS_W-1:DIM_W]);
        o_py    <= dim_to_pos(arg_pos[DIM_W-1:0]);
      end
    end
  end

  assign m_tdata = OUT_W'({o_ch, o_py, o_px, o_val});

endmodule
